// ===== hdl/prefix_code_bit_packer_top_macros.svh =====
// assertion macros used by the pcbp_packer module of the prefix code bit packer
`ifndef PREFIX_CODE_BIT_PACKER_TOP_MACROS_SVH
`define PREFIX_CODE_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCBP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PCBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pcbp_pkg.sv =====
// shared types and constants of the prefix code bit packer
package pcbp_pkg;

    localparam int SYMBOL_W  = 8;
    localparam int LEN_W     = 6;
    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 3;
    localparam int ACC_W     = 7;
    localparam int BYTES_MAX = 5;
    localparam int WIN_W     = BYTES_MAX * BYTE_W;
    localparam int CNT_W     = 3;
    localparam int HW_LEN_MAX = 32;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOL_COUNT = 256;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] word;
    } code_entry_t;

    typedef struct packed {
        logic fin;
        logic hit;
    } lookup_t;

endpackage

// ===== hdl/pcbp_code_ram.sv =====
// code table memory, one write port and one registered read port
module pcbp_code_ram
    import pcbp_pkg::*;
#(
    parameter int DEPTH  = DEF_SYMBOL_COUNT,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  code_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output code_entry_t       rd_data
);

    code_entry_t mem [DEPTH];
    code_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pcbp_packer.sv =====
// bit accumulator and byte burst output stage
`include "prefix_code_bit_packer_top_macros.svh"

module pcbp_packer
    import pcbp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              lk_valid,
    output logic              lk_ready,
    input  lookup_t           lk_info,
    input  code_entry_t       lk_entry,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_packed_byte,
    output logic              m_stream_end
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              end_reg, end_next;
    logic              bvalid_reg, bvalid_next;

    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  shl;
    logic [WIN_W-1:0]  val;
    logic [WIN_W-1:0]  aligned;
    logic [CNT_W-1:0]  nbytes;
    logic [PEND_W-1:0] rem;
    logic [CNT_W-1:0]  emit_cnt;
    logic [WIN_W-1:0]  out_shift;
    logic              last;
    logic              hold;
    logic              take;

    always_comb begin
        if (!lk_info.hit) begin
            len_eff = '0;
        end else if (lk_entry.len > LEN_W'(HW_LEN_MAX)) begin
            len_eff = LEN_W'(HW_LEN_MAX);
        end else begin
            len_eff = lk_entry.len;
        end
        val = (WIN_W'(acc_reg) << len_eff)
            | (WIN_W'(lk_entry.word) & ~({WIN_W{1'b1}} << len_eff));
        total   = LEN_W'(pend_reg) + len_eff;
        shl     = LEN_W'(WIN_W) - total;
        aligned = val << shl;
        nbytes  = total[LEN_W-1:PEND_W];
        rem     = total[PEND_W-1:0];
        emit_cnt = nbytes
            + CNT_W'(lk_info.fin && ((rem != '0) || (nbytes == '0)));
    end

    assign last      = (idx_reg == (cnt_reg - CNT_W'(1)));
    assign hold      = bvalid_reg && !(m_ready && last);
    assign lk_ready  = (emit_cnt == '0) || !hold;
    assign take      = lk_valid && lk_ready;
    assign out_shift = win_reg << {idx_reg, 3'b000};

    assign m_valid       = bvalid_reg;
    assign m_packed_byte = out_shift[WIN_W-1 -: BYTE_W];
    assign m_stream_end  = end_reg && last;

    always_comb begin
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        win_next    = win_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        end_next    = end_reg;
        bvalid_next = bvalid_reg;
        if (bvalid_reg && m_ready) begin
            if (last) begin
                bvalid_next = 1'b0;
            end else begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        if (take) begin
            if (lk_info.fin) begin
                acc_next  = '0;
                pend_next = '0;
            end else begin
                acc_next  = val[ACC_W-1:0] & ~({ACC_W{1'b1}} << rem);
                pend_next = rem;
            end
            if (emit_cnt != '0) begin
                win_next    = aligned;
                cnt_next    = emit_cnt;
                idx_next    = '0;
                end_next    = lk_info.fin;
                bvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            end_reg    <= 1'b0;
            bvalid_reg <= 1'b0;
        end else begin
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            end_reg    <= end_next;
            bvalid_reg <= bvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    `PCBP_ASSERT_NOW(a_burst_shape, aclk, aresetn, bvalid_reg,
        (cnt_reg != '0) && (idx_reg < cnt_reg) && (cnt_reg <= CNT_W'(BYTES_MAX)),
        "burst count or index out of range")
    `PCBP_ASSERT_NEXT(a_flush_clears, aclk, aresetn, take && lk_info.fin,
        (pend_reg == '0) && (acc_reg == '0), "flush left bits pending")
    `PCBP_ASSERT_NOW(a_acc_fits, aclk, aresetn, 1'b1,
        (acc_reg & ~({ACC_W{1'b1}} >> (PEND_W'(ACC_W) - pend_reg))) == '0,
        "accumulator holds bits beyond the pending count")
    `PCBP_ASSERT_NOW(a_no_overwrite, aclk, aresetn, take && (emit_cnt != '0),
        !hold, "burst loaded over undelivered bytes")

endmodule

// ===== hdl/prefix_code_bit_packer_top.sv =====
// Prefix code bit packer. Items with s_mode = 0 load one code table entry (length saturated
// to min(MAX_CODE_LEN, 32); symbols beyond SYMBOL_COUNT are dropped); items with s_mode = 1
// encode one symbol, its code bits packed MSB first into bytes on the m_ channel, with a
// zero-padded final byte and m_stream_end on the symbol flagged s_final_symbol. One item
// enters per cycle while s_ready is high: the table is read into a registered lookup on
// accept, and the packer loads its byte window from it when free, so the first byte of an
// item is valid on m_ once the window is loaded. The output port drains one byte per cycle
// while m_ready is high; an item that yields up to 5 bytes holds the port until all are
// taken, and the next byte-producing item waits behind it. The table is not reset.
module prefix_code_bit_packer_top
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [SYMBOL_W-1:0] s_symbol,
    input  logic [LEN_W-1:0]    s_code_length,
    input  logic [WORD_W-1:0]   s_code_word,
    input  logic                s_final_symbol,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_packed_byte,
    output logic                m_stream_end
);

    localparam int LEN_BOUND = (MAX_CODE_LEN < HW_LEN_MAX) ? MAX_CODE_LEN : HW_LEN_MAX;
    localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    logic        accept;
    logic        hit;
    logic        lk_ready;
    logic        s1_valid_reg;
    lookup_t     s1_info_reg;
    code_entry_t wr_entry;
    code_entry_t rd_entry;

    assign hit     = ({1'b0, s_symbol} < (SYMBOL_W+1)'(SYMBOL_COUNT));
    assign s_ready = !s1_valid_reg || lk_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        wr_entry.word = s_code_word;
        if (s_code_length > LEN_W'(LEN_BOUND)) begin
            wr_entry.len = LEN_W'(LEN_BOUND);
        end else begin
            wr_entry.len = s_code_length;
        end
    end

    pcbp_code_ram #(
        .DEPTH  (SYMBOL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_code_ram (
        .aclk    (aclk),
        .wr_en   (accept && (s_mode == MODE_LOAD) && hit),
        .wr_addr (s_symbol[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (accept && (s_mode == MODE_ENCODE)),
        .rd_addr (s_symbol[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= (s_mode == MODE_ENCODE);
        end else if (lk_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg.fin <= s_final_symbol;
            s1_info_reg.hit <= hit;
        end
    end

    pcbp_packer u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .lk_valid      (s1_valid_reg),
        .lk_ready      (lk_ready),
        .lk_info       (s1_info_reg),
        .lk_entry      (rd_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_stream_end  (m_stream_end)
    );

endmodule

// ===== tb/sv/prefix_code_bit_packer_top_tb.sv =====
// testbench for the prefix code bit packer: table loads, symbol encoding and byte output checks
`timescale 1ns / 1ps

module prefix_code_bit_packer_top_tb
    import pcbp_pkg::*;
();

    localparam int CLK_HALF   = 5;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_WAIT = 16;
    localparam int IDLE_PCT   = 31;
    localparam int LEN_BOUND  = (DEF_MAX_CODE_LEN < 32) ? DEF_MAX_CODE_LEN : 32;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              stream_end;
    } out_byte_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_mode;
    logic [SYMBOL_W-1:0] s_symbol;
    logic [LEN_W-1:0]    s_code_length;
    logic [WORD_W-1:0]   s_code_word;
    logic                s_final_symbol;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_packed_byte;
    logic                m_stream_end;

    logic [LEN_W-1:0]  code_len_tbl  [DEF_SYMBOL_COUNT];
    logic [WORD_W-1:0] code_word_tbl [DEF_SYMBOL_COUNT];
    logic [BYTE_W-1:0] acc_bits;
    int                acc_count;
    out_byte_t         expected_bytes[$];

    bit loaded_flag [DEF_SYMBOL_COUNT];
    int loaded_syms[$];
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_req_cycles;
    int error_count;
    int quiet_cycles;

    prefix_code_bit_packer_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_symbol       (s_symbol),
        .s_code_length  (s_code_length),
        .s_code_word    (s_code_word),
        .s_final_symbol (s_final_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_byte  (m_packed_byte),
        .m_stream_end   (m_stream_end)
    );

    always #CLK_HALF aclk = ~aclk;

    // works out the bytes that one accepted item produces
    function automatic void pack_code_bits(logic mode, logic [SYMBOL_W-1:0] sym,
                                           logic [LEN_W-1:0] len, logic [WORD_W-1:0] word,
                                           logic fin);
        int        nbits;
        int        n;
        int        i;
        logic [BYTE_W-1:0] flushed;
        out_byte_t ob;
        n = 0;
        if (mode == MODE_LOAD) begin
            if (int'(sym) < DEF_SYMBOL_COUNT) begin
                code_len_tbl[sym]  = (int'(len) > LEN_BOUND) ? LEN_W'(LEN_BOUND) : len;
                code_word_tbl[sym] = word;
            end
            return;
        end
        nbits = 0;
        if (int'(sym) < DEF_SYMBOL_COUNT) begin
            nbits = int'(code_len_tbl[sym]);
            if (nbits > 32) nbits = 32;
        end
        for (i = nbits - 1; i >= 0; i--) begin
            acc_bits = {acc_bits[BYTE_W-2:0], code_word_tbl[sym][i]};
            acc_count++;
            if (acc_count == BYTE_W) begin
                ob.packed_byte = acc_bits;
                ob.stream_end  = 1'b0;
                expected_bytes.push_back(ob);
                n++;
                acc_bits  = '0;
                acc_count = 0;
            end
        end
        if (fin) begin
            if (acc_count != 0) begin
                flushed        = acc_bits << (BYTE_W - acc_count);
                ob.packed_byte = flushed;
                ob.stream_end  = 1'b1;
                expected_bytes.push_back(ob);
            end else if (n > 0) begin
                expected_bytes[$].stream_end = 1'b1;
            end else begin
                ob.packed_byte = '0;
                ob.stream_end  = 1'b1;
                expected_bytes.push_back(ob);
            end
            acc_bits  = '0;
            acc_count = 0;
        end
    endfunction

    task automatic send_item(logic mode, logic [SYMBOL_W-1:0] sym, logic [LEN_W-1:0] len,
                             logic [WORD_W-1:0] word, logic fin);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_symbol       <= sym;
        s_code_length  <= len;
        s_code_word    <= word;
        s_final_symbol <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pack_code_bits(mode, sym, len, word, fin);
    endtask

    task automatic load_code(logic [SYMBOL_W-1:0] sym, logic [LEN_W-1:0] len,
                             logic [WORD_W-1:0] word);
        send_item(MODE_LOAD, sym, len, word, 1'($urandom));
        if (!loaded_flag[sym]) begin
            loaded_flag[sym] = 1'b1;
            loaded_syms.push_back(int'(sym));
        end
    endtask

    task automatic encode_symbol(logic [SYMBOL_W-1:0] sym, logic fin);
        send_item(MODE_ENCODE, sym, LEN_W'($urandom), WORD_W'($urandom), fin);
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_loaded();
        return SYMBOL_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(0, 63));
        return LEN_W'($urandom_range(1, 12));
    endfunction

    task automatic test_directed_codes();
        load_code(8'h00, 6'd0,  32'hFFFF_FFFF);
        load_code(8'hFF, 6'd32, 32'h8000_0001);
        load_code(8'h01, 6'd1,  32'h0000_0001);
        load_code(8'h02, 6'd8,  32'h0000_00B7);
        load_code(8'h03, 6'd63, 32'hC3A5_5A3C);
        load_code(8'h04, 6'd7,  32'h0000_0055);
        load_code(8'h05, 6'd33, 32'h0000_0000);
        // byte-aligned finish, then empty finish with padding byte
        encode_symbol(8'h02, 1'b1);
        encode_symbol(8'h00, 1'b1);
        encode_symbol(8'h01, 1'b0);
        encode_symbol(8'h04, 1'b0);
        encode_symbol(8'h00, 1'b1);
        // seven pending bits plus a 32-bit code gives five bytes
        encode_symbol(8'h04, 1'b0);
        encode_symbol(8'hFF, 1'b1);
        encode_symbol(8'h01, 1'b1);
        // saturated lengths
        encode_symbol(8'h03, 1'b0);
        encode_symbol(8'h05, 1'b1);
        encode_symbol(8'h04, 1'b1);
        load_code(8'h02, 6'd3, 32'hFFFF_FFFA);
        encode_symbol(8'h02, 1'b0);
        encode_symbol(8'h02, 1'b1);
    endtask

    task automatic test_random_streams();
        int round;
        int k;
        int sent;
        int stream_len;
        for (round = 0; round < 3; round++) begin
            tx_idle_on = (round != 1);
            rx_idle_on = (round != 1);
            for (k = 0; k < 10; k++) begin
                load_code(SYMBOL_W'($urandom), random_length(), WORD_W'($urandom));
            end
            sent = 0;
            while (sent < 60) begin
                stream_len = $urandom_range(1, 10);
                for (k = 0; k < stream_len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        load_code(SYMBOL_W'($urandom), random_length(), WORD_W'($urandom));
                    end
                    encode_symbol(pick_loaded(), k == stream_len - 1);
                    sent++;
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        logic [SYMBOL_W-1:0] long_syms [4];
        int k;
        for (k = 0; k < 4; k++) begin
            long_syms[k] = SYMBOL_W'($urandom);
            load_code(long_syms[k], LEN_W'($urandom_range(24, 32)), WORD_W'($urandom));
        end
        hold_req_cycles = 300;
        for (k = 0; k < 32; k++) begin
            encode_symbol(long_syms[$urandom_range(0, 3)], (k % 8) == 7);
        end
    endtask

    task automatic finish_run();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("prefix_code_bit_packer_top_tb: done, clean");
        end else begin
            $display("prefix_code_bit_packer_top_tb: done, errors");
        end
        $finish;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = MODE_LOAD;
        s_symbol        = '0;
        s_code_length   = '0;
        s_code_word     = '0;
        s_final_symbol  = 1'b0;
        acc_bits        = '0;
        acc_count       = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        hold_req_cycles = 0;
        error_count     = 0;
        foreach (loaded_flag[i]) loaded_flag[i] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_codes();
        test_random_streams();
        test_output_stall();
        finish_run();
    end

    // receiver with random stalls and a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req_cycles > 0) begin
                hold_left       = hold_req_cycles;
                hold_req_cycles = 0;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        out_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h stream_end %0b", $time,
                         m_packed_byte, m_stream_end);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_packed_byte !== want.packed_byte) begin
                    $display("%0t: packed_byte expected %02h, got %02h", $time,
                             want.packed_byte, m_packed_byte);
                    error_count++;
                end
                if (m_stream_end !== want.stream_end) begin
                    $display("%0t: stream_end expected %0b, got %0b", $time,
                             want.stream_end, m_stream_end);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("prefix_code_bit_packer_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
